@@ rtl/rrlp_pkg.sv @@
// Shared constants, types and the entry packing function of the run-length packer.
package rrlp_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned VALUE_W = 24;

	localparam logic [COUNT_W-1:0] RUN_MAX    = 7'd127;
	localparam logic               ENTRY_FLAG = 1'b1;

	// Output queue geometry: room for two pushes per transaction plus draining.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;
	localparam int unsigned QCNT_W      = 3;

	typedef struct packed {
		logic               last;
		logic [WORD_W-1:0]  entry;
	} entry_t;

	function automatic logic [WORD_W-1:0] pack_entry(
		input logic [WORD_W-1:0]  value,
		input logic [COUNT_W-1:0] count
	);
		pack_entry = {ENTRY_FLAG, count, value[VALUE_W-1:0]};
	endfunction

endpackage

@@ rtl/rate_run_length_packer.sv @@
// Top level of the run-length packer: input register, run state and output queue.
//
//  channel  | signals                                  | payload
//  s_axis   | tvalid tready tdata[31:0] tlast          | rate_value, is_last
//  m_axis   | tvalid tready tdata[31:0] tlast          | packed_entry, last_entry
//
// One rate word is accepted per cycle while the output queue has room for two entries.
// A word is registered, then folded into the run state once stage 1 advances; an entry
// it closes is written into the output queue in the same cycle as that fold.
// The four-entry output queue decouples stalls on m_axis from the input side.
// Reset clears the run state, the input stage valid and the queue pointers.
module rate_run_length_packer
	import rrlp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] rate_value
	input  logic        s_axis_tlast,   // is_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] packed_entry
	output logic        m_axis_tlast    // last_entry
);

	logic                valid_s1;
	logic [WORD_W-1:0]   value_s1;
	logic                last_s1;

	logic [WORD_W-1:0]   run_value_q;
	logic [COUNT_W-1:0]  run_count_q;
	logic                run_open_q;

	entry_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	logic                advance;
	logic                extend;
	logic                close_run;
	logic [WORD_W-1:0]   next_value;
	logic [COUNT_W-1:0]  next_count;
	logic                push_a;
	logic                push_b;
	entry_t              entry_a;
	entry_t              entry_b;
	logic                pop;
	logic [QPTR_W-1:0]   wr_ptr_b;
	logic [1:0]          push_n;

	// Stage 1 moves on only when the queue can take both possible entries.
	assign advance       = valid_s1 && (count_q <= QCNT_W'(QUEUE_DEPTH - 2));
	assign s_axis_tready = !valid_s1 || advance;

	assign extend    = run_open_q && (value_s1 == run_value_q) && (run_count_q < RUN_MAX);
	assign close_run = run_open_q && !extend;

	always_comb begin
		if (extend) begin
			next_value = run_value_q;
			next_count = run_count_q + COUNT_W'(1);
		end else begin
			next_value = value_s1;
			next_count = COUNT_W'(1);
		end
	end

	assign entry_a = '{last: 1'b0, entry: pack_entry(run_value_q, run_count_q)};
	assign entry_b = '{last: 1'b1, entry: pack_entry(next_value, next_count)};

	assign push_a = advance && close_run;
	assign push_b = advance && last_s1;
	assign push_n = {1'b0, push_a} + {1'b0, push_b};

	// The flush entry lands behind the closed entry when both are written.
	assign wr_ptr_b = push_a ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;

	assign pop           = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tdata  = queue_q[rd_ptr_q].entry;
	assign m_axis_tlast  = queue_q[rd_ptr_q].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			value_s1 <= s_axis_tdata;
			last_s1  <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_value_q <= '0;
			run_count_q <= '0;
			run_open_q  <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				run_value_q <= '0;
				run_count_q <= '0;
				run_open_q  <= 1'b0;
			end else begin
				run_value_q <= next_value;
				run_count_q <= next_count;
				run_open_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_a) begin
			queue_q[wr_ptr_q] <= entry_a;
		end
		if (push_b) begin
			queue_q[wr_ptr_b] <= entry_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push_n) - QCNT_W'(pop);
		end
	end

endmodule

@@ rtl/rrlp_checker.sv @@
// Port-level checker for the run-length packer and its bind statement.
module rrlp_checker
	import rrlp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [31:0] s_axis_tdata,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// A stalled input transaction keeps its payload until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=>
			s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
		else $error("s_axis payload changed while stalled");

	// A stalled output transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("m_axis payload changed while stalled");

	// Every entry carries the marker bit.
	a_flag_set: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31] == ENTRY_FLAG)
		else $error("packed entry without marker bit");

	// A run is never empty.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[30:24] != '0)
		else $error("packed entry with zero run count");

	// The output queue starts empty when reset is released.
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("output valid right after reset");

endmodule

bind rate_run_length_packer rrlp_checker u_rrlp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

@@ dv/rate_run_length_packer_tb.sv @@
// Self-checking testbench for the run-length packer of rate words.
`timescale 1ns / 1ps

module rate_run_length_packer_tb;
	import rrlp_pkg::*;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [WORD_W-1:0] s_axis_tdata  = '0;     // [31:0] rate_value
	logic              s_axis_tlast  = 1'b0;   // is_last
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [WORD_W-1:0] m_axis_tdata;           // [31:0] packed_entry
	logic              m_axis_tlast;           // last_entry

	// Predicted run state and the entries still owed by the block.
	logic [WORD_W-1:0]  run_value = '0;
	logic [COUNT_W-1:0] run_count = '0;
	logic               run_open  = 1'b0;
	entry_t             pending_entries[$];

	int send_idle_pct = 11;
	int recv_idle_pct = 68;
	int errors        = 0;

	rate_run_length_packer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #6 clk = ~clk;

	function automatic void queue_packed_entry(input logic last);
		entry_t e;
		e.entry = {ENTRY_FLAG, run_count, run_value[VALUE_W-1:0]};
		e.last  = last;
		pending_entries.push_back(e);
	endfunction

	// Folds one accepted rate word into the predicted run and records closed runs.
	function automatic void fold_rate_word(input logic [WORD_W-1:0] value, input logic last);
		if (!run_open) begin
			run_value = value;
			run_count = COUNT_W'(1);
			run_open  = 1'b1;
		end else if (value == run_value && run_count != RUN_MAX) begin
			run_count = run_count + COUNT_W'(1);
		end else begin
			queue_packed_entry(1'b0);
			run_value = value;
			run_count = COUNT_W'(1);
		end
		if (last) begin
			queue_packed_entry(1'b1);
			run_value = '0;
			run_count = '0;
			run_open  = 1'b0;
		end
	endfunction

	function automatic void check_packed_entry(input logic [WORD_W-1:0] data, input logic last);
		entry_t want;
		if (pending_entries.size() == 0) begin
			$display("%0t: entry %h last %b arrived with none expected", $time, data, last);
			errors++;
		end else begin
			want = pending_entries.pop_front();
			if (data !== want.entry) begin
				$display("%0t: packed_entry expected %h actual %h", $time, want.entry, data);
				errors++;
			end
			if (last !== want.last) begin
				$display("%0t: last_entry expected %b actual %b", $time, want.last, last);
				errors++;
			end
		end
	endfunction

	// Output side: checks each transaction and stalls at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				check_packed_entry(m_axis_tdata, m_axis_tlast);
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic send_word(input logic [WORD_W-1:0] value, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		fold_rate_word(value, last);
	endtask

	// Single-word streams, value extremes, words equal in the low 24 bits only,
	// a change on the last word and a fresh stream that starts with zero.
	task automatic test_stream_edges();
		logic [WORD_W:0] words [15];
		words = '{
			{1'b1, 32'hFFFF_FFFF}, {1'b0, 32'h0000_0000}, {1'b0, 32'h0000_0000},
			{1'b0, 32'h0100_0000}, {1'b0, 32'h8000_0000}, {1'b0, 32'h8000_0000},
			{1'b1, 32'h8000_0001}, {1'b1, 32'h0000_0000}, {1'b0, 32'h1234_5678},
			{1'b1, 32'h1234_5678}, {1'b0, 32'h55AA_AA55}, {1'b0, 32'hAA55_55AA},
			{1'b0, 32'h7FFF_FFFF}, {1'b0, 32'hFFFF_FF00}, {1'b1, 32'hFFFF_FF00}
		};
		foreach (words[i])
			send_word(words[i][WORD_W-1:0], words[i][WORD_W]);
	endtask

	// A run that fills up is closed by the next equal word, which opens a new run.
	task automatic test_full_run();
		logic [WORD_W-1:0] value;
		value = $urandom;
		for (int i = 0; i < RUN_MAX + 1; i++)
			send_word(value, 1'b0);
		send_word(value, 1'b1);
	endtask

	task automatic test_random_streams(input int item_target);
		int                sent;
		int                len;
		bit                long_run;
		logic [WORD_W-1:0] word;
		sent = 0;
		word = $urandom;
		while (sent < item_target) begin
			long_run = ($urandom_range(0, 39) == 0);
			len      = long_run ? $urandom_range(120, 135) : $urandom_range(1, 12);
			for (int k = 0; k < len; k++) begin
				if (!long_run) begin
					case ($urandom_range(0, 9))
						5, 6: word = $urandom;
						7:    word = word ^ (32'h1 << $urandom_range(24, 31));
						8:    word = word ^ (32'h1 << $urandom_range(0, 23));
						9:    word = $urandom_range(0, 1) ? '1 : '0;
						default: ;
					endcase
				end
				send_word(word, k == len - 1);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_stream_edges();
		test_full_run();
		test_random_streams(80);

		send_idle_pct = 68;
		recv_idle_pct = 11;
		test_random_streams(80);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_streams(80);

		s_axis_tvalid <= 1'b0;
		while (pending_entries.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("rate_run_length_packer_tb OK");
		else
			$display("rate_run_length_packer_tb NOT OK");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("%0t: timeout", $time);
		$display("rate_run_length_packer_tb NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
rtl/rrlp_pkg.sv
rtl/rate_run_length_packer.sv
rtl/rrlp_checker.sv
dv/rate_run_length_packer_tb.sv
